[hw/rtl/rd_pkg.sv]
// Shared types and constants for the recency deque.
// Used by rd_cell and recency_deque; depends on nothing else.
package rd_pkg;

	// Number of cells in the chain, i.e. the most tags the list holds.
	localparam int CAPACITY = 16;
	// Width of the internal fill count; it must be able to hold CAPACITY itself.
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// Fixed widths of the request and response fields.
	localparam int TAG_W    = 32;
	localparam int OP_W     = 3;
	localparam int ENTRY_W  = 5;

	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Operation codes carried on the op field. Codes 5 to 7 mean nothing.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_POP_FRONT  = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_MOVE_FRONT = 3'd3,
		OP_CONTAINS   = 3'd4
	} op_t;

	// Per-cell load selects. At most one is set in a cycle; none means hold.
	typedef struct packed {
		logic take_value;   // load the request tag
		logic take_prev;    // load the tag of the neighbor nearer the front
		logic take_next;    // load the tag of the neighbor nearer the back
	} cell_ctl_t;

endpackage

[hw/rtl/recency_deque.sv]
// Top level of the recency deque: a chain of rd_cell slots, the fill count,
// operation decode and the response register. Depends on rd_pkg and rd_cell.
//
// Channel    Direction  Handshake               Payload
// request    in         in_valid / in_ready     op, value
// response   out        out_valid / out_ready   out_value, hit, was_empty, was_full,
//                                               entry_count
//
// For every request all cells compare and shift in parallel, and the
// response is registered at the same edge that updates the chain.
// A new request is taken in every cycle while the response register is empty or
// is being drained; a stalled response holds the request side, nothing is lost.
// The longest path is the first-match chain through the cells and the per-cell
// load select that depends on it.
// Reset clears the fill count and the response valid; tag registers need none.
module recency_deque (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rd_pkg::OP_W-1:0]   op,
	input  rd_pkg::tag_t              value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rd_pkg::tag_t              out_value,
	output logic                      hit,
	output logic                      was_empty,
	output logic                      was_full,
	output logic [rd_pkg::ENTRY_W-1:0] entry_count
);
	import rd_pkg::*;

	// Fill count: cells below it are occupied, front at cell zero.
	cnt_t count_q;
	cnt_t count_next;

	// Response register.
	logic               out_valid_q;
	tag_t               out_value_q;
	logic               hit_q;
	logic               was_empty_q;
	logic               was_full_q;
	logic [ENTRY_W-1:0] entry_count_q;

	logic accept;
	logic is_full;
	logic is_empty;
	logic any_hit;

	// Decoded operations, already qualified by the list state.
	logic do_push;
	logic do_pop_front;
	logic do_pop_back;
	logic do_move;
	logic is_search;

	// Chain wiring. Entry i of seen_w and tail_w enters cell i; the last entry
	// leaves the back of the chain.
	tag_t      tag_w  [CAPACITY];
	logic      valid_w[CAPACITY];
	logic      seen_w [CAPACITY+1];
	tag_t      tail_w [CAPACITY+1];

	assign accept   = in_valid && in_ready;
	// The response register parts the two sides: a request is taken whenever no
	// response waits or the waiting response leaves in the same cycle.
	assign in_ready = !out_valid_q || out_ready;

	assign is_full  = (count_q == cnt_t'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign seen_w[0] = 1'b0;
	assign tail_w[0] = '0;
	assign any_hit   = seen_w[CAPACITY];

	assign do_push      = accept && (op == OP_PUSH_FRONT) && !is_full;
	assign do_pop_front = accept && (op == OP_POP_FRONT) && !is_empty;
	assign do_pop_back  = accept && (op == OP_POP_BACK) && !is_empty;
	// A move with the match already in front reloads the same tag into cell
	// zero and leaves the rest alone, so it needs no special handling.
	assign do_move      = accept && (op == OP_MOVE_FRONT) && any_hit;
	assign is_search    = (op == OP_MOVE_FRONT) || (op == OP_CONTAINS);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		tag_t      prev_tag;
		tag_t      next_tag;
		logic      valid_next;
		cell_ctl_t ctl;

		assign valid_w[i] = (cnt_t'(i) < count_q);

		if (i == 0) begin : g_front
			assign prev_tag = value;
		end else begin : g_inner
			assign prev_tag = tag_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_back
			assign next_tag   = tag_w[i];
			assign valid_next = 1'b0;
		end else begin : g_mid
			assign next_tag   = tag_w[i+1];
			assign valid_next = valid_w[i+1];
		end

		// Push and move put the request tag in front. The rest of the chain
		// shifts back by one: all of it for a push, and for a move only the
		// cells up to and including the first match, which have not yet seen it.
		always_comb begin
			ctl = '0;
			if (i == 0) begin
				ctl.take_value = do_push || do_move;
			end else begin
				ctl.take_prev = do_push || (do_move && !seen_w[i]);
			end
			ctl.take_next = do_pop_front;
		end

		rd_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (value),
			.prev_tag   (prev_tag),
			.next_tag   (next_tag),
			.valid      (valid_w[i]),
			.valid_next (valid_next),
			.seen_in    (seen_w[i]),
			.tail_in    (tail_w[i]),
			.tag        (tag_w[i]),
			.seen_out   (seen_w[i+1]),
			.tail_out   (tail_w[i+1])
		);
	end

	always_comb begin
		count_next = count_q;
		if (do_push) begin
			count_next = count_q + cnt_t'(1);
		end else if (do_pop_front || do_pop_back) begin
			count_next = count_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload. Pops of an empty list answer all ones; a pop from the
	// back takes the tag selected by the tail chain.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q   <= '0;
			was_empty_q   <= 1'b0;
			was_full_q    <= 1'b0;
			hit_q         <= is_search && any_hit;
			entry_count_q <= ENTRY_W'(count_next);
			if ((op == OP_POP_FRONT) || (op == OP_POP_BACK)) begin
				if (is_empty) begin
					out_value_q <= '1;
					was_empty_q <= 1'b1;
				end else if (op == OP_POP_FRONT) begin
					out_value_q <= tag_w[0];
				end else begin
					out_value_q <= tail_w[CAPACITY];
				end
			end
			if ((op == OP_PUSH_FRONT) && is_full) begin
				was_full_q <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign hit         = hit_q;
	assign was_empty   = was_empty_q;
	assign was_full    = was_full_q;
	assign entry_count = entry_count_q;

	// The fill count never passes the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("fill count above capacity");

	// A push that is taken while room remains grows the list by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_PUSH_FRONT) && !is_full)
		|=> (count_q == $past(count_q) + cnt_t'(1)))
		else $error("push did not grow the list");

	// Searches never change the fill count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((op == OP_MOVE_FRONT) || (op == OP_CONTAINS)))
		|=> (count_q == $past(count_q)))
		else $error("search changed the fill count");

	// A response carries at most one of hit, empty and full.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({hit_q, was_empty_q, was_full_q}))
		else $error("conflicting response flags");

	// The reported count matches the list state left by the request.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (entry_count_q == ENTRY_W'(count_q)))
		else $error("reported count differs from fill count");

endmodule

[hw/rtl/rd_cell.sv]
// One slot of the recency chain: a tag register, its compare against the
// request tag, and the links of the first-match and tail-select chains.
// Depends on rd_pkg.
module rd_cell (
	input  logic              clk,
	input  rd_pkg::cell_ctl_t ctl,
	input  rd_pkg::tag_t      value,
	input  rd_pkg::tag_t      prev_tag,
	input  rd_pkg::tag_t      next_tag,
	input  logic              valid,
	input  logic              valid_next,
	input  logic              seen_in,
	input  rd_pkg::tag_t      tail_in,
	output rd_pkg::tag_t      tag,
	output logic              seen_out,
	output rd_pkg::tag_t      tail_out
);
	import rd_pkg::*;

	tag_t tag_q;
	logic match;

	always_ff @(posedge clk) begin
		if (ctl.take_value) begin
			tag_q <= value;
		end else if (ctl.take_prev) begin
			tag_q <= prev_tag;
		end else if (ctl.take_next) begin
			tag_q <= next_tag;
		end
	end

	assign tag      = tag_q;
	assign match    = valid && (tag_q == value);
	// Set from the first matching cell onward toward the back.
	assign seen_out = seen_in | match;
	// Only the last occupied cell contributes its tag.
	assign tail_out = tail_in | ((valid && !valid_next) ? tag_q : '0);

endmodule
